>>> rtl/sogi_pkg.sv
// Shared constants for the SOGI quadrature filter.
package sogi_pkg;

    localparam int unsigned WORD_W = 32;

    // configuration register indexes
    localparam logic [0:0] REG_RES_GAIN      = 1'b0;
    localparam logic [0:0] REG_SAMPLE_PERIOD = 1'b1;

    localparam logic [31:0] RES_GAIN_RST      = 32'd16777216;
    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd429497;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_X    = 4'd1;
    localparam logic [3:0] ST_SQ   = 4'd2;
    localparam logic [3:0] ST_C    = 4'd3;
    localparam logic [3:0] ST_E    = 4'd4;
    localparam logic [3:0] ST_CE   = 4'd5;
    localparam logic [3:0] ST_TF   = 4'd6;
    localparam logic [3:0] ST_CY   = 4'd7;
    localparam logic [3:0] ST_Y    = 4'd8;
    localparam logic [3:0] ST_CYN  = 4'd9;
    localparam logic [3:0] ST_DIV  = 4'd10;
    localparam logic [3:0] ST_FIN  = 4'd11;

endpackage

>>> rtl/sogi_mul_serial.sv
// Shift-and-add multiplier, one multiplier bit per cycle, signed operands.
module sogi_mul_serial
    import sogi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [33:0] op_a,
    input  logic signed [33:0] op_b,
    output logic               done,
    output logic signed [67:0] prod
);
    logic signed [67:0] acc_reg, acc_next;
    logic signed [67:0] mcand_reg, mcand_next;
    logic [33:0]        mplier_reg, mplier_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done        = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = 68'(op_a);
            mplier_next = op_b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // top bit of a two's complement multiplier carries negative weight
            if (mplier_reg[0])
            begin
                if (cnt_reg == 6'd33)
                    acc_next = acc_reg - mcand_reg;
                else
                    acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 6'd1;
            if (cnt_reg == 6'd33)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign prod = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule

>>> rtl/sogi_quadrature_filter_top.sv
// Top level of the SOGI quadrature filter: sequencer, state and divider.
//
// Fixed-point second-order generalised integrator. Each input beat carries
// one grid sample (signed Q8.24) and the angular frequency w0 (unsigned
// Q16.16); one output beat returns alpha and beta (signed Q8.24, saturated).
// One item is worked on at a time. Seven products go through one shared
// bit-serial multiplier (each a load step, then 34 bit steps). Alpha is
// registered when the last resonator product completes. Beta then goes
// through a restoring divider (a load step, then one quotient bit a cycle,
// 64 bits in all). The result is then handed to the output register, which
// offers the result beat. s_axis_tready is held low while the sequencer is
// busy and while a result still waits, so the next item is taken only once
// the result beat has left. Configuration is written through
// cfg_valid/cfg_ready, index 0 = Kr (Q8.24), index 1 = Ts (Q0.32); other
// indexes are ignored.
module sogi_quadrature_filter_top
    import sogi_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] sample_in, [63:32] ang_freq
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] alpha_out, [63:32] beta_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    // saturation range; widths above 32 behave as 32
    localparam int SB = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam logic signed [67:0] DW_MAX = (68'sd1 <<< (SB - 1)) - 68'sd1;
    localparam logic signed [67:0] DW_MIN = -DW_MAX - 68'sd1;

    function automatic logic signed [31:0] sat(input logic signed [67:0] v);
        if (v > DW_MAX) return 32'(DW_MAX);
        if (v < DW_MIN) return 32'(DW_MIN);
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] sat_c(input logic signed [67:0] v);
        if (v > 68'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -68'sh8000_0000) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    logic [31:0] kr_reg, ts_reg;
    logic signed [31:0] pe_reg, py_reg, py2_reg;
    logic signed [31:0] u_reg;
    logic [31:0] w0_reg;
    logic [31:0] x_reg;
    logic signed [31:0] c_reg, e_reg, y_reg;
    logic signed [67:0] t_reg;     // running sum / numerator
    logic [3:0]  st_reg;
    logic        go_reg;
    logic        ov_reg;
    logic [31:0] ao_reg, bo_reg;

    // divider
    logic [63:0] dq_reg;           // magnitude of numerator -> quotient
    logic [31:0] dr_reg;           // partial remainder (< x)
    logic [6:0]  dc_reg;
    logic        dneg_reg;

    // multiplier
    logic               m_start;
    logic signed [33:0] m_a, m_b;
    logic               m_done;
    logic signed [67:0] m_p;

    sogi_mul_serial u_mul (
        .clk(clk), .rst_n(rst_n), .start(m_start), .op_a(m_a), .op_b(m_b),
        .done(m_done), .prod(m_p)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (st_reg == ST_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {bo_reg, ao_reg};

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // operand selection for each multiplier pass
    logic signed [31:0] d_val;
    assign d_val = sat(68'(u_reg) - 68'(py_reg));

    always_comb
    begin
        m_a = '0;
        m_b = '0;
        case (st_reg)
            ST_X:   begin m_a = 34'({1'b0, w0_reg}); m_b = 34'({1'b0, ts_reg}); end
            ST_SQ:  begin m_a = 34'({1'b0, x_reg});  m_b = 34'({1'b0, x_reg});  end
            ST_E:   begin m_a = 34'(d_val);          m_b = 34'({1'b0, kr_reg}); end
            ST_CE:  begin m_a = 34'(c_reg);          m_b = 34'(pe_reg);        end
            ST_TF:
            begin
                m_a = 34'($signed(t_reg[31:0]));
                m_b = 34'({1'b0, ts_reg});
            end
            ST_CY:  begin m_a = 34'(c_reg);          m_b = 34'(py_reg);        end
            ST_CYN: begin m_a = 34'(c_reg);          m_b = 34'(y_reg);         end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    assign m_start = go_reg;

    logic [64:0] half_sq;
    assign half_sq = 65'(m_p) >> 1;
    logic signed [67:0] c_full;
    assign c_full = ((68'sd1 <<< 48) - $signed(68'(half_sq))) >>> 24;

    logic [32:0] dtrial;
    assign dtrial = {dr_reg, dq_reg[63]} - {1'b0, x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            go_reg  <= 1'b0;
            ov_reg  <= 1'b0;
            kr_reg  <= RES_GAIN_RST;
            ts_reg  <= SAMPLE_PERIOD_RST;
            pe_reg  <= '0;
            py_reg  <= '0;
            py2_reg <= '0;
            dc_reg  <= '0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == REG_RES_GAIN)      kr_reg <= cfg_data;
                if (cfg_index == REG_SAMPLE_PERIOD) ts_reg <= cfg_data;
            end
            if (ov_reg && m_axis_tready)
                ov_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        st_reg <= ST_X;
                        go_reg <= 1'b1;
                    end
                end
                ST_X:
                    if (m_done)
                    begin
                        x_reg  <= (m_p[67:56] != '0) ? 32'hFFFF_FFFF : m_p[55:24];
                        st_reg <= ST_SQ;
                        go_reg <= 1'b1;
                    end
                ST_SQ:
                    if (m_done)
                    begin
                        c_reg  <= sat_c(c_full);
                        st_reg <= ST_E;
                        go_reg <= 1'b1;
                    end
                ST_E:
                    if (m_done)
                    begin
                        e_reg  <= sat(m_p >>> 24);
                        st_reg <= ST_CE;
                        go_reg <= 1'b1;
                    end
                ST_CE:
                    if (m_done)
                    begin
                        t_reg  <= 68'(sat(68'(e_reg) - (m_p >>> 24)));
                        st_reg <= ST_TF;
                        go_reg <= 1'b1;
                    end
                ST_TF:
                    if (m_done)
                    begin
                        t_reg  <= (m_p >>> 32) - 68'(py2_reg);
                        st_reg <= ST_CY;
                        go_reg <= 1'b1;
                    end
                ST_CY:
                    if (m_done)
                    begin
                        y_reg  <= sat(t_reg + (m_p >>> 23));
                        st_reg <= ST_Y;
                    end
                ST_Y:
                begin
                    st_reg <= ST_CYN;
                    go_reg <= 1'b1;
                end
                ST_CYN:
                    if (m_done)
                    begin
                        t_reg <= (68'(py_reg) <<< 24) - m_p;
                        st_reg <= ST_DIV;
                        dc_reg <= '0;
                    end
                ST_DIV:
                begin
                    if (dc_reg == 7'd0)
                    begin
                        // load magnitude of numerator (fits in 64 bits)
                        dneg_reg <= t_reg[67];
                        dq_reg   <= t_reg[67] ? 64'(-t_reg) : 64'(t_reg);
                        dr_reg   <= '0;
                        dc_reg   <= 7'd1;
                    end
                    else
                    begin
                        if (!dtrial[32])
                            dr_reg <= dtrial[31:0];
                        else
                            dr_reg <= {dr_reg[30:0], dq_reg[63]};
                        dq_reg <= {dq_reg[62:0], !dtrial[32]};
                        dc_reg <= dc_reg + 7'd1;
                        if (dc_reg == 7'd64)
                            st_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!ov_reg || m_axis_tready)
                    begin
                        ao_reg  <= y_reg;
                        bo_reg  <= (x_reg == '0) ? 32'd0 :
                            sat(dneg_reg ? -68'(dq_reg) : 68'(dq_reg));
                        ov_reg  <= 1'b1;
                        pe_reg  <= e_reg;
                        py2_reg <= py_reg;
                        py_reg  <= y_reg;
                        st_reg  <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // input payload captured on acceptance
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            u_reg  <= $signed(s_axis_tdata[31:0]);
            w0_reg <= s_axis_tdata[63:32];
        end
    end

    // assertions
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_FIN && !ov_reg) |=> (st_reg == ST_IDLE && ov_reg))
        else $error("result not delivered");
    a_start_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (st_reg == ST_X && go_reg))
        else $error("multiplier not started");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the SOGI quadrature filter top level.
module testbench;
    import sogi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] sample_in, [63:32] ang_freq
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [31:0] alpha_out, [63:32] beta_out
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    sogi_quadrature_filter_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    localparam int      DATA_WIDTH_TB = 32;
    localparam int      SAT_W  = (DATA_WIDTH_TB > 32) ? 32 : DATA_WIDTH_TB;
    localparam longint  SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 1;
    localparam longint  SAT_LO = -SAT_HI - 1;

    // predictor copy of the registers and filter state
    logic [31:0] kr_gain;
    logic [31:0] ts_period;
    longint      err_q;
    longint      y_q1;
    longint      y_q2;

    logic [63:0] pending_beats[$];
    int          fail_count;
    logic        hold_off;      // long receiver stall in progress
    logic        stall_on;      // patterned receiver stall enable

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch %s got %h want %h", what, got, want);
        fail_count++;
    endtask

    function automatic longint sat_word(input longint v);
        if (v < SAT_LO) return SAT_LO;
        if (v > SAT_HI) return SAT_HI;
        return v;
    endfunction

    // floor division by 2^s (>>> on longint is arithmetic: floor)
    function automatic longint fshr(input longint v, input int s);
        return v >>> s;
    endfunction

    // one filter step: updates the state copy, returns {beta, alpha}
    function automatic logic [63:0] sogi_step(input logic [31:0] u_raw,
                                              input logic [31:0] w0);
        logic [63:0] xw;
        logic [63:0] ang;
        logic [63:0] half_sq;
        longint      cosw;
        longint      u, d, e, f, acc, y, beta, num;
        xw = ({32'd0, w0} * {32'd0, ts_period}) >> 24;
        ang = (xw > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : xw;
        half_sq = (ang * ang) >> 1;
        cosw = fshr((64'sd1 <<< 48) - longint'(half_sq), 24);
        if (cosw < -64'sd2147483648) cosw = -64'sd2147483648;
        if (cosw > 64'sd2147483647) cosw = 64'sd2147483647;
        u = longint'($signed(u_raw));
        d = sat_word(u - y_q1);
        e = sat_word(fshr(d * longint'({32'd0, kr_gain}), 24));
        f = sat_word(e - fshr(cosw * err_q, 24));
        acc = fshr(f * longint'({32'd0, ts_period}), 32) + fshr(cosw * y_q1, 23) - y_q2;
        y = sat_word(acc);
        if (ang == 0)
            beta = 0;
        else
        begin
            num = y_q1 * 64'sd16777216 - cosw * y;
            beta = sat_word(num / longint'(ang));
        end
        err_q = e;
        y_q2 = y_q1;
        y_q1 = y;
        return {beta[31:0], y[31:0]};
    endfunction

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_RES_GAIN) kr_gain = val;
        else ts_period = val;
        @(posedge clk);
    endtask

    // one input beat; prediction made at acceptance
    task automatic send_sample(input logic [31:0] u, input logic [31:0] w0);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w0, u};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_beats.push_back(sogi_step(u, w0));
    endtask

    // bursty sender: gap drops valid only between beats
    task automatic send_gap();
        int n;
        n = $urandom_range(0, 3);
        if ($urandom_range(0, 4) != 0) n = 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_beats.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        // sequencer may still be busy after the last beat left
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // realistic grid: w0 near 314 rad/s, samples within a few units
    function automatic logic [31:0] grid_freq();
        return 32'd20578304 + $urandom_range(0, 1 << 20) - (1 << 19);
    endfunction

    function automatic logic [31:0] grid_sample();
        return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endfunction

    task automatic test_directed();
        send_sample(32'h0100_0000, 32'd20578304);
        send_sample(32'h7FFF_FFFF, 32'd20578304);
        send_sample(32'h8000_0000, 32'd20578304);
        send_sample(32'h0000_0000, 32'd0);          // zero angle step
        send_sample(32'h0100_0000, 32'd0);
        send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);  // large angle step
        send_sample(32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001);
        send_sample(32'h0000_0001, 32'h8000_0000);
        send_sample(32'hFF00_0000, 32'd20578304);
        send_sample(32'h8000_0000, 32'd0);
        send_sample(32'h7FFF_FFFF, 32'd0);
        drain();
    endtask

    task automatic test_grid(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(rand_word(), rand_word());
            else
                send_sample(grid_sample(), grid_freq());
            send_gap();
        end
        drain();
    endtask

    // receiver stalls long while the sender keeps offering beats
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 10; i++)
                send_sample(grid_sample(), grid_freq());
        join
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(REG_RES_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        test_grid(150);
        write_reg(REG_RES_GAIN, 32'h0000_0000);
        write_reg(REG_SAMPLE_PERIOD, 32'h0000_0000);
        test_grid(150);
        write_reg(REG_RES_GAIN, 32'h0200_0000);
        write_reg(REG_SAMPLE_PERIOD, 32'd858993);
        test_grid(250);
        write_reg(REG_RES_GAIN, $urandom);
        write_reg(REG_SAMPLE_PERIOD, $urandom);
        test_grid(150);
        write_reg(REG_RES_GAIN, RES_GAIN_RST);
        write_reg(REG_SAMPLE_PERIOD, SAMPLE_PERIOD_RST);
        test_grid(200);
    endtask

    // receiver: own stall pattern plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && !(stall_on && ($urandom_range(0, 2) == 0));
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_on <= 1'b0;
        else if ($urandom_range(0, 499) == 0)
            stall_on <= !stall_on;
    end

    // result checker
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_axis_tdata[31:0] !== want[31:0])
                    report_mismatch("alpha_out", m_axis_tdata[31:0], want[31:0]);
                if (m_axis_tdata[63:32] !== want[63:32])
                    report_mismatch("beta_out", m_axis_tdata[63:32], want[63:32]);
            end
        end
    end

    initial
    begin
        fail_count    = 0;
        hold_off      = 1'b0;
        kr_gain       = RES_GAIN_RST;
        ts_period     = SAMPLE_PERIOD_RST;
        err_q         = 0;
        y_q1          = 0;
        y_q2          = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_grid(380);
        test_config_sweep();
        if (pending_beats.size() != 0)
        begin
            $display("tb: %0d results never arrived", pending_beats.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ~1300 items plus stalls, taken several times over
    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sogi_pkg.sv
rtl/sogi_mul_serial.sv
rtl/sogi_quadrature_filter_top.sv
test/testbench.sv
